### rtl/core/iee_pkg.sv
// shared types and constants for the infix expression evaluator
package iee_pkg;

    localparam int FracBits   = 32;
    localparam int NumberBits = 31;
    localparam int ValueBits  = 64;

    localparam logic [2:0] OP_MARK = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam logic [ValueBits-1:0] VAL_MAX = {1'b0, {(ValueBits-1){1'b1}}};
    localparam logic [ValueBits-1:0] VAL_MIN = {1'b1, {(ValueBits-1){1'b0}}};

    // controller to datapath
    typedef struct packed {
        logic       load;      // take a new character
        logic       finish;    // accumulate a digit or push the pending number
        logic       flush;     // push the pending number at end of line
        logic       push_op;   // push the decoded operator
        logic       red_start; // pop operator and operands, start arithmetic
        logic       red_step;  // advance multicycle arithmetic
        logic       red_done;  // push the arithmetic result
        logic       clear;     // back to the reset state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       is_digit;
        logic       is_op;
        logic       can_reduce; // top operator binds at least as tight as the new one
        logic       ops_left;   // anything above the marker
        logic       arith_busy;
    } t_status;

    function automatic logic [1:0] prec(input logic [2:0] op);
        return (op == OP_MUL || op == OP_DIV) ? 2'd2 : 2'd1;
    endfunction

endpackage

### rtl/core/iee_datapath.sv
// stacks, number accumulator and shift-add multiply / restoring divide unit
module iee_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [7:0]                    i_char_code,
    input  iee_pkg::t_cmd                 i_cmd,
    output iee_pkg::t_status              o_status,
    output logic [iee_pkg::ValueBits-1:0] o_result,
    output logic                          o_dbz
);
    localparam int W = iee_pkg::ValueBits;
    localparam int F = iee_pkg::FracBits;
    localparam int N = iee_pkg::NumberBits;

    logic [7:0]   r_char;
    logic [2:0]   r_ops [3];
    logic [1:0]   r_op_cnt;
    logic [W-1:0] r_vals [3];
    logic [1:0]   r_val_cnt;
    logic [N-1:0] r_acc;
    logic         r_in_num;
    logic         r_dbz;

    // arithmetic unit
    logic [2:0]     r_aop;
    logic [W-1:0]   r_lhs, r_rhs;
    logic           r_neg;
    logic [W-1:0]   r_x, r_d;       // magnitudes
    logic [2*W-1:0] r_num;          // dividend shift / product
    logic [W:0]     r_rem;
    logic [W-1:0]   r_q;
    logic           r_ovf;
    logic [7:0]     r_cnt;
    logic           r_busy;

    logic [2:0] dec_op;
    logic       is_digit;

    always_comb begin
        case (r_char)
            iee_pkg::CH_PLUS:  dec_op = iee_pkg::OP_ADD;
            iee_pkg::CH_MINUS: dec_op = iee_pkg::OP_SUB;
            iee_pkg::CH_STAR:  dec_op = iee_pkg::OP_MUL;
            iee_pkg::CH_SLASH: dec_op = iee_pkg::OP_DIV;
            default:           dec_op = iee_pkg::OP_MARK;
        endcase
    end

    assign is_digit = (r_char >= iee_pkg::CH_ZERO) && (r_char <= iee_pkg::CH_NINE);

    logic [2:0] top_op;
    assign top_op = r_ops[r_op_cnt - 2'd1];

    assign o_status.is_digit   = is_digit;
    assign o_status.is_op      = dec_op != iee_pkg::OP_MARK;
    assign o_status.ops_left   = r_op_cnt > 2'd1;
    assign o_status.can_reduce = (r_op_cnt > 2'd1) &&
                                 (iee_pkg::prec(top_op) >= iee_pkg::prec(dec_op));
    assign o_status.arith_busy = r_busy;

    assign o_result = (r_val_cnt != 2'd0) ? r_vals[r_val_cnt - 2'd1] : '0;
    assign o_dbz    = r_dbz;

    // digit accumulate with saturation
    logic [N+3:0] acc_next;
    logic [N-1:0] acc_sat;
    always_comb begin
        acc_next = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                 + {{(N){1'b0}}, r_char[3:0] - iee_pkg::CH_ZERO[3:0]};
        acc_sat  = (acc_next > {4'b0000, {N{1'b1}}}) ? {N{1'b1}} : acc_next[N-1:0];
    end

    // operand fetch at reduce start
    logic [W-1:0] f_rhs, f_lhs;
    logic [1:0]   f_cnt;
    always_comb begin
        f_rhs = '0;
        f_lhs = '0;
        f_cnt = r_val_cnt;
        if (f_cnt != 2'd0) begin
            f_rhs = r_vals[f_cnt - 2'd1];
            f_cnt = f_cnt - 2'd1;
        end
        if (f_cnt != 2'd0) begin
            f_lhs = r_vals[f_cnt - 2'd1];
            f_cnt = f_cnt - 2'd1;
        end
    end

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] from_mag(input logic [W-1:0] m, input logic neg,
                                              input logic ovf);
        logic [W-1:0] r;
        if (neg) begin
            if (ovf || m[W-1]) r = iee_pkg::VAL_MIN;
            else r = ~m + 1'b1;
        end else begin
            if (ovf || m[W-1]) r = iee_pkg::VAL_MAX;
            else r = m;
        end
        return r;
    endfunction

    // add / subtract with saturation
    logic [W-1:0] b_eff, sum;
    logic         sum_ovf;
    always_comb begin
        b_eff   = (r_aop == iee_pkg::OP_SUB) ? (~r_rhs + 1'b1) : r_rhs;
        sum     = (r_aop == iee_pkg::OP_SUB) ? (r_lhs - r_rhs) : (r_lhs + r_rhs);
        if (r_aop == iee_pkg::OP_SUB)
            sum_ovf = (r_lhs[W-1] != r_rhs[W-1]) && (sum[W-1] != r_lhs[W-1]);
        else
            sum_ovf = (r_lhs[W-1] == b_eff[W-1]) && (sum[W-1] != r_lhs[W-1]);
    end

    // one restoring divide step, and one shift-add multiply step
    logic [W:0]   rem_sh, rem_sub;
    logic         div_bit;
    logic [2*W-1:0] mul_add;
    always_comb begin
        rem_sh  = {r_rem[W-1:0], r_num[2*W-1]};
        div_bit = rem_sh >= {1'b0, r_d};
        rem_sub = div_bit ? (rem_sh - {1'b0, r_d}) : rem_sh;
        mul_add = r_num + (r_d[r_cnt[5:0]] ? ({{W{1'b0}}, r_x} << r_cnt[5:0]) : '0);
    end

    logic [W-1:0] arith_res;
    logic         mul_hi_ovf;
    always_comb begin
        mul_hi_ovf = |r_num[2*W-1:W+F];
        case (r_aop)
            iee_pkg::OP_ADD, iee_pkg::OP_SUB:
                arith_res = sum_ovf ? (r_lhs[W-1] ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX)
                                    : sum;
            iee_pkg::OP_MUL:
                arith_res = from_mag(r_num[W+F-1:F], r_neg, mul_hi_ovf);
            default: begin
                if (r_rhs == '0)
                    arith_res = (r_lhs == '0) ? '0 :
                                (r_lhs[W-1] ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX);
                else
                    arith_res = from_mag(r_q, r_neg, r_ovf);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_op_cnt  <= 2'd1;
            r_val_cnt <= 2'd0;
            r_acc     <= '0;
            r_in_num  <= 1'b0;
            r_dbz     <= 1'b0;
            r_busy    <= 1'b0;
            r_ops[0]  <= iee_pkg::OP_MARK;
        end else begin
            if (i_cmd.load) begin
                r_char <= i_char_code;
            end
            if (i_cmd.load && (i_char_code >= iee_pkg::CH_ZERO)
                           && (i_char_code <= iee_pkg::CH_NINE)) begin
                r_in_num <= 1'b1;
            end
            if (i_cmd.finish && is_digit) begin
                r_acc <= acc_sat;
            end else if ((i_cmd.finish || i_cmd.flush) && r_in_num) begin
                if (r_val_cnt < 2'd3) begin
                    r_vals[r_val_cnt] <= {{(W-N-F){1'b0}}, r_acc, {F{1'b0}}};
                    r_val_cnt         <= r_val_cnt + 2'd1;
                end
                r_in_num <= 1'b0;
                r_acc    <= '0;
            end
            if (i_cmd.push_op && r_op_cnt < 2'd3) begin
                r_ops[r_op_cnt] <= dec_op;
                r_op_cnt        <= r_op_cnt + 2'd1;
            end
            if (i_cmd.red_start) begin
                r_aop     <= top_op;
                r_op_cnt  <= r_op_cnt - 2'd1;
                r_val_cnt <= f_cnt;
                r_lhs     <= f_lhs;
                r_rhs     <= f_rhs;
                r_x       <= mag(f_lhs);
                r_d       <= mag(f_rhs);
                r_neg     <= f_lhs[W-1] != f_rhs[W-1];
                r_rem     <= '0;
                r_q       <= '0;
                r_ovf     <= 1'b0;
                r_cnt     <= '0;
                r_busy    <= (top_op == iee_pkg::OP_MUL) ||
                             ((top_op == iee_pkg::OP_DIV) && (f_rhs != '0));
                if (top_op == iee_pkg::OP_DIV && f_rhs == '0) begin
                    r_dbz <= 1'b1;
                end
                if (top_op == iee_pkg::OP_MUL)
                    r_num <= '0;
                else
                    r_num <= {mag(f_lhs), {W{1'b0}}} >> (W - F);
            end
            if (i_cmd.red_step && r_busy) begin
                if (r_aop == iee_pkg::OP_MUL) begin
                    r_num <= mul_add;
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'(W - 1)) r_busy <= 1'b0;
                end else begin
                    r_rem <= rem_sub;
                    r_num <= {r_num[2*W-2:0], 1'b0};
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt < 8'(W)) begin
                        if (div_bit) r_ovf <= 1'b1;
                    end else begin
                        r_q <= {r_q[W-2:0], div_bit};
                    end
                    if (r_cnt == 8'(2*W - 1)) r_busy <= 1'b0;
                end
            end
            if (i_cmd.red_done && r_val_cnt < 2'd3) begin
                r_vals[r_val_cnt] <= arith_res;
                r_val_cnt         <= r_val_cnt + 2'd1;
            end
        end
    end
endmodule

### rtl/core/iee_ctrl.sv
// sequencing state machine for character handling and reductions
module iee_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_end_of_line,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  iee_pkg::t_status i_status,
    output iee_pkg::t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIN   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;
    localparam logic [2:0] S_EOL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_eol, r_final;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = (!i_status.is_digit && i_status.is_op) ? S_CHK : S_EOL;
            end
            S_CHK: begin
                if (r_final ? i_status.ops_left : i_status.can_reduce) begin
                    o_cmd.red_start = 1'b1;
                    n_state = S_RUN;
                end else begin
                    n_state = r_final ? S_OUT : S_PUSH;
                end
            end
            S_RUN: begin
                o_cmd.red_step = 1'b1;
                if (!i_status.arith_busy) begin
                    o_cmd.red_step = 1'b0;
                    o_cmd.red_done = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_PUSH: begin
                o_cmd.push_op = 1'b1;
                n_state = S_EOL;
            end
            S_EOL: begin
                if (r_eol) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eol   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_eol   <= i_end_of_line;
                r_final <= 1'b0;
            end
            if (r_state == S_EOL && r_eol) r_final <= 1'b1;
            if (r_state == S_OUT && i_out_ready) r_final <= 1'b0;
        end
    end
endmodule

### rtl/core/infix_expression_evaluator_top.sv
// top level of the infix expression evaluator
// Takes one expression character per input transaction (i_char_code) with
// i_end_of_line marking the last character of a line. Digits form unsigned
// decimal numbers, + - * / are operators with usual precedence, all other
// characters separate. On the last character of a line one result
// transaction carries o_result_value (signed, 32 fraction bits) and
// o_divide_by_zero.
// Reductions: an operator character also runs every reduction it pops. A
// multiply reduction goes through a shift-add unit, one bit per cycle, a
// divide through a restoring divider, one bit per cycle, over the 128-bit
// shifted dividend; add, subtract and a divide by zero skip the multicycle
// unit. An operator can pop two operators; end of line adds a reduction
// for every operator left before the result is offered.
// One character is processed at a time; o_in_ready is low while busy.
// The result holds on the outputs while i_out_ready is low, and no new
// character is taken until the result transaction completes.
// Reset leaves empty stacks and clears the divide-by-zero flag.
module infix_expression_evaluator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_line,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [63:0] o_result_value,
    output logic        o_divide_by_zero
);
    iee_pkg::t_cmd    cmd;
    iee_pkg::t_status status;
    logic [iee_pkg::ValueBits-1:0] result;

    iee_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_end_of_line (i_end_of_line),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    iee_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result),
        .o_dbz       (o_divide_by_zero)
    );

    assign o_result_value = $signed(result);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and result valid together");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value))
        else $error("result changed while stalled");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.red_start, cmd.red_done, cmd.push_op, cmd.clear}) <= 1)
        else $error("conflicting datapath commands");
endmodule
